// ===== design/fts_pkg.sv =====
package fts_pkg;

    localparam int FLOW_ENTRIES_DEF = 64;
    localparam int WORKER_IDS_DEF   = 16;
    localparam int WORKER_SLOTS_DEF = 8;

    // shortest packet that carries a full key
    localparam int KEY_BYTES = 8;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_DATA_W-1:0] SLOT_COUNT_RESET = 4'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLED    = 1'b0,
        CFG_SLOT_COUNT = 1'b1
    } cfg_index_e;

    typedef enum logic [2:0] {
        ACT_PACKET     = 3'd0,
        ACT_ADD        = 3'd1,
        ACT_REMOVE     = 3'd2,
        ACT_REGISTER   = 3'd3,
        ACT_UNREGISTER = 3'd4
    } action_e;

    typedef enum logic [3:0] {
        ST_MAPPED   = 4'd0,
        ST_RR       = 4'd1,
        ST_DISABLED = 4'd2,
        ST_SHORT    = 4'd3,
        ST_ZERO     = 4'd4,
        ST_NOWORKER = 4'd5,
        ST_UNREG    = 4'd6,
        ST_FLOW     = 4'd7,
        ST_FULL     = 4'd8,
        ST_WORKER   = 4'd9
    } status_e;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] flow_key;
        logic [10:0] packet_length;
        logic [3:0]  worker;
    } item_t;

    typedef struct packed {
        logic [3:0] status;
        logic [3:0] dest_worker;
    } result_t;

    typedef enum logic [1:0] {
        WR_UPDATE = 2'd0,
        WR_INSERT = 2'd1,
        WR_REMOVE = 2'd2,
        WR_CLEAR  = 2'd3
    } flow_wr_e;

    typedef struct packed {
        logic     load;
        logic     check;
        logic     wr_en;
        flow_wr_e wr_kind;
    } flow_cmd_t;

    typedef struct packed {
        logic       key_zero;
        logic       len_short;
        logic       scan_done;
        logic       hit;
        logic [3:0] hit_worker;
        logic       free_found;
    } flow_sts_t;

    typedef struct packed {
        logic load;
        logic set_mark;
        logic clr_mark;
        logic claim;
        logic release_slot;
        logic advance;
        logic rr_step;
    } wrk_cmd_t;

    typedef struct packed {
        logic       id_ok;
        logic       cnt_done;
        logic       free_here;
        logic       match_here;
        logic       used_cap;
        logic       rr_ok;
        logic [3:0] rr_worker;
        logic       hit_ok;
    } wrk_sts_t;

    typedef enum logic [3:0] {
        S_CLEAR       = 4'd0,
        S_IDLE        = 4'd1,
        S_FL_READ     = 4'd2,
        S_FL_CHECK    = 4'd3,
        S_RR_READ     = 4'd4,
        S_RR_CHECK    = 4'd5,
        S_REG_SCAN    = 4'd6,
        S_UNREG_READ  = 4'd7,
        S_UNREG_CHECK = 4'd8,
        S_DONE        = 4'd9
    } state_e;

endpackage

// ===== design/fts_flow_table.sv =====
module fts_flow_table #(
    parameter int FLOW_ENTRIES = fts_pkg::FLOW_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fts_pkg::item_t    item,
    input  fts_pkg::flow_cmd_t cmd,
    output fts_pkg::flow_sts_t sts
);
    import fts_pkg::*;

    localparam int AW = $clog2(FLOW_ENTRIES);
    localparam int CW = AW + 1;

    typedef struct packed {
        logic        valid;
        logic [3:0]  worker;
        logic [63:0] key;
    } entry_t;

    entry_t flow_mem [FLOW_ENTRIES];

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          hit_reg, hit_next;
    logic          free_reg, free_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;
    logic [3:0]    hit_wrk_reg, hit_wrk_next;
    logic [63:0]   key_reg, key_next;
    logic [3:0]    wrk_reg, wrk_next;
    entry_t        rd_reg;

    logic [AW-1:0] cnt_idx;
    logic          match;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    assign cnt_idx = cnt_reg[AW-1:0];
    assign match   = rd_reg.valid && (rd_reg.key == key_reg);

    always_comb
    begin
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        free_next     = free_reg;
        hit_idx_next  = hit_idx_reg;
        free_idx_next = free_idx_reg;
        hit_wrk_next  = hit_wrk_reg;
        key_next      = key_reg;
        wrk_next      = wrk_reg;
        if (cmd.load)
        begin
            cnt_next  = '0;
            hit_next  = 1'b0;
            free_next = 1'b0;
            key_next  = item.flow_key;
            wrk_next  = item.worker;
        end
        if (cmd.check)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (match && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cnt_idx;
                hit_wrk_next = rd_reg.worker;
            end
            if (!rd_reg.valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = cnt_idx;
            end
        end
        if (cmd.wr_en && (cmd.wr_kind == WR_CLEAR))
        begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_comb
    begin
        wr_data.valid  = 1'b1;
        wr_data.worker = wrk_reg;
        wr_data.key    = key_reg;
        case (cmd.wr_kind)
            WR_UPDATE: wr_addr = hit_idx_reg;
            WR_INSERT: wr_addr = free_idx_reg;
            WR_REMOVE:
            begin
                wr_addr       = hit_idx_reg;
                wr_data.valid = 1'b0;
            end
            WR_CLEAR:
            begin
                wr_addr = cnt_idx;
                wr_data = '0;
            end
            default: wr_addr = cnt_idx;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            hit_reg  <= hit_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        hit_wrk_reg  <= hit_wrk_next;
        key_reg      <= key_next;
        wrk_reg      <= wrk_next;
    end

    // single write port, one registered read at the scan index
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            flow_mem[wr_addr] <= wr_data;
        end
        rd_reg <= flow_mem[cnt_idx];
    end

    assign sts.key_zero   = (item.flow_key == '0);
    assign sts.len_short  = (item.packet_length < 11'(KEY_BYTES));
    assign sts.scan_done  = (cnt_reg == CW'(FLOW_ENTRIES));
    assign sts.hit        = hit_reg;
    assign sts.hit_worker = hit_wrk_reg;
    assign sts.free_found = free_reg;

    a_check_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.check |-> !sts.scan_done)
        else $error("flow scan checked past the last entry");

    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && (cmd.wr_kind == WR_INSERT)) |-> (free_reg && !hit_reg))
        else $error("flow insert without a free entry or over a held key");

endmodule

// ===== design/fts_workers.sv =====
module fts_workers #(
    parameter int WORKER_IDS   = fts_pkg::WORKER_IDS_DEF,
    parameter int WORKER_SLOTS = fts_pkg::WORKER_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [fts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fts_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  fts_pkg::item_t                    item,
    input  logic [3:0]                        hit_worker,
    input  fts_pkg::wrk_cmd_t                 cmd,
    output fts_pkg::wrk_sts_t                 sts
);
    import fts_pkg::*;

    localparam int SAW = (WORKER_SLOTS > 1) ? $clog2(WORKER_SLOTS) : 1;
    localparam int SCW = $clog2(WORKER_SLOTS + 1);
    localparam int NW  = (SCW > CFG_DATA_W) ? SCW : CFG_DATA_W;
    localparam int IDW = $clog2(WORKER_IDS);
    localparam int IXW = IDW + 4;

    logic [3:0] slot_mem [WORKER_SLOTS];

    logic [CFG_DATA_W-1:0]   slot_count_reg, slot_count_next;
    logic [WORKER_IDS-1:0]   registered_reg, registered_next;
    logic [WORKER_SLOTS-1:0] used_reg, used_next;
    logic [SAW-1:0]          ptr_reg, ptr_next;
    logic [SCW-1:0]          s_cnt_reg, s_cnt_next;
    logic [3:0]              wid_reg, wid_next;
    logic                    used_cap_reg, used_cap_next;
    logic [3:0]              rd_reg;

    logic [NW-1:0]  count_x;
    logic [NW-1:0]  n_x;
    logic [SCW-1:0] n;
    logic [SCW-1:0] ptr_x;
    logic [SCW-1:0] rr_x;
    logic [SCW-1:0] rr_inc;
    logic [SCW-1:0] rr_wrap;
    logic [SAW-1:0] rr_idx;
    logic [SAW-1:0] s_idx;
    logic [SAW-1:0] rd_addr;

    function automatic logic id_ok_f(input logic [3:0] w);
        return IXW'(w) < IXW'(WORKER_IDS);
    endfunction

    function automatic logic [IDW-1:0] id_idx_f(input logic [3:0] w);
        logic [IXW-1:0] wx;
        wx = IXW'(w);
        return wx[IDW-1:0];
    endfunction

    // slot count clamped to 1..WORKER_SLOTS
    assign count_x = NW'(slot_count_reg);
    assign n_x     = (count_x == '0) ? NW'(1) :
                     ((count_x > NW'(WORKER_SLOTS)) ? NW'(WORKER_SLOTS) : count_x);
    assign n       = n_x[SCW-1:0];

    // pointer outside the active slots restarts at zero
    assign ptr_x   = SCW'(ptr_reg);
    assign rr_x    = (ptr_x >= n) ? '0 : ptr_x;
    assign rr_inc  = rr_x + SCW'(1);
    assign rr_wrap = (rr_inc >= n) ? '0 : rr_inc;
    assign rr_idx  = rr_x[SAW-1:0];
    assign s_idx   = s_cnt_reg[SAW-1:0];
    assign rd_addr = cmd.rr_step ? rr_idx : s_idx;

    always_comb
    begin
        slot_count_next = slot_count_reg;
        registered_next = registered_reg;
        used_next       = used_reg;
        ptr_next        = ptr_reg;
        s_cnt_next      = s_cnt_reg;
        wid_next        = wid_reg;
        used_cap_next   = used_cap_reg;
        if (cfg_write && (cfg_index == CFG_SLOT_COUNT))
        begin
            slot_count_next = cfg_data;
        end
        if (cmd.load)
        begin
            s_cnt_next = '0;
            wid_next   = item.worker;
        end
        if (cmd.set_mark && id_ok_f(wid_reg))
        begin
            registered_next[id_idx_f(wid_reg)] = 1'b1;
        end
        if (cmd.clr_mark && id_ok_f(wid_reg))
        begin
            registered_next[id_idx_f(wid_reg)] = 1'b0;
        end
        if (cmd.claim)
        begin
            used_next[s_idx] = 1'b1;
        end
        if (cmd.release_slot)
        begin
            used_next[s_idx] = 1'b0;
        end
        if (cmd.advance || cmd.rr_step)
        begin
            s_cnt_next = s_cnt_reg + SCW'(1);
        end
        if (cmd.rr_step)
        begin
            ptr_next      = rr_wrap[SAW-1:0];
            used_cap_next = used_reg[rr_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RESET;
            registered_reg <= '0;
            used_reg       <= '0;
            ptr_reg        <= '0;
            s_cnt_reg      <= '0;
        end
        else
        begin
            slot_count_reg <= slot_count_next;
            registered_reg <= registered_next;
            used_reg       <= used_next;
            ptr_reg        <= ptr_next;
            s_cnt_reg      <= s_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wid_reg      <= wid_next;
        used_cap_reg <= used_cap_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.claim)
        begin
            slot_mem[s_idx] <= wid_reg;
        end
        rd_reg <= slot_mem[rd_addr];
    end

    assign sts.id_ok      = id_ok_f(wid_reg);
    assign sts.cnt_done   = (s_cnt_reg >= n);
    assign sts.free_here  = !used_reg[s_idx];
    assign sts.match_here = used_reg[s_idx] && (rd_reg == wid_reg);
    assign sts.used_cap   = used_cap_reg;
    assign sts.rr_worker  = rd_reg;
    assign sts.rr_ok      = id_ok_f(rd_reg) && registered_reg[id_idx_f(rd_reg)];
    assign sts.hit_ok     = id_ok_f(hit_worker) && registered_reg[id_idx_f(hit_worker)];

    a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim |-> (!sts.cnt_done && sts.free_here && sts.id_ok))
        else $error("slot claimed that is busy or outside the slot count");

    a_release_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.release_slot |-> (!sts.cnt_done && sts.match_here))
        else $error("slot released that does not hold the worker");

endmodule

// ===== design/fts_ctrl.sv =====
module fts_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  fts_pkg::item_t                  item,
    input  logic                            cfg_write,
    input  logic [fts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  fts_pkg::flow_sts_t              fsts,
    input  fts_pkg::wrk_sts_t               wsts,
    output fts_pkg::flow_cmd_t              fcmd,
    output fts_pkg::wrk_cmd_t               wcmd,
    output logic                            result_valid,
    input  logic                            result_stall,
    output fts_pkg::result_t                result
);
    import fts_pkg::*;

    state_e  state_reg, state_next;
    action_e op_reg, op_next;
    logic    enabled_reg, enabled_next;
    status_e fin_status_reg, fin_status_next;
    logic [3:0] fin_target_reg, fin_target_next;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    logic    accept;
    action_e act;
    logic    fin;
    status_e fin_st;
    logic [3:0] fin_tg;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && (state_reg == S_IDLE);
    assign act        = action_e'(item.action);

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        enabled_next      = enabled_reg;
        fin_status_next   = fin_status_reg;
        fin_target_next   = fin_target_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        fcmd              = '0;
        wcmd              = '0;
        fin               = 1'b0;
        fin_st            = ST_DISABLED;
        fin_tg            = '0;

        if (cfg_write && (cfg_index == CFG_ENABLED))
        begin
            enabled_next = cfg_data[0];
        end
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                if (fsts.scan_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    fcmd.wr_en   = 1'b1;
                    fcmd.wr_kind = WR_CLEAR;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = act;
                    fcmd.load = 1'b1;
                    wcmd.load = 1'b1;
                    case (act)
                        ACT_PACKET:
                        begin
                            if (!enabled_reg)
                            begin
                                fin = 1'b1;
                            end
                            else if (fsts.len_short)
                            begin
                                fin    = 1'b1;
                                fin_st = ST_SHORT;
                            end
                            else if (fsts.key_zero)
                            begin
                                fin    = 1'b1;
                                fin_st = ST_ZERO;
                            end
                            else
                            begin
                                state_next = S_FL_READ;
                            end
                        end
                        ACT_ADD, ACT_REMOVE:
                        begin
                            if (!enabled_reg)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FL_READ;
                            end
                        end
                        ACT_REGISTER:   state_next = S_REG_SCAN;
                        ACT_UNREGISTER: state_next = S_UNREG_READ;
                        default:        fin = 1'b1;
                    endcase
                end
            end
            S_FL_READ:
            begin
                if (fsts.hit || fsts.scan_done)
                begin
                    case (op_reg)
                        ACT_PACKET:
                        begin
                            if (fsts.hit)
                            begin
                                fin    = 1'b1;
                                fin_st = wsts.hit_ok ? ST_MAPPED : ST_UNREG;
                                fin_tg = wsts.hit_ok ? fsts.hit_worker : 4'd0;
                            end
                            else
                            begin
                                state_next = S_RR_READ;
                            end
                        end
                        ACT_ADD:
                        begin
                            fin    = 1'b1;
                            fin_st = ST_FLOW;
                            if (fsts.hit)
                            begin
                                fcmd.wr_en   = 1'b1;
                                fcmd.wr_kind = WR_UPDATE;
                            end
                            else if (fsts.free_found)
                            begin
                                fcmd.wr_en   = 1'b1;
                                fcmd.wr_kind = WR_INSERT;
                            end
                            else
                            begin
                                fin_st = ST_FULL;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            fin          = 1'b1;
                            fin_st       = ST_FLOW;
                            fcmd.wr_en   = fsts.hit;
                            fcmd.wr_kind = WR_REMOVE;
                        end
                        default: fin = 1'b1;
                    endcase
                end
                else
                begin
                    state_next = S_FL_CHECK;
                end
            end
            S_FL_CHECK:
            begin
                fcmd.check = 1'b1;
                state_next = S_FL_READ;
            end
            S_RR_READ:
            begin
                if (wsts.cnt_done)
                begin
                    fin    = 1'b1;
                    fin_st = ST_NOWORKER;
                end
                else
                begin
                    wcmd.rr_step = 1'b1;
                    state_next   = S_RR_CHECK;
                end
            end
            S_RR_CHECK:
            begin
                if (wsts.used_cap)
                begin
                    fin    = 1'b1;
                    fin_st = wsts.rr_ok ? ST_RR : ST_UNREG;
                    fin_tg = wsts.rr_ok ? wsts.rr_worker : 4'd0;
                end
                else
                begin
                    state_next = S_RR_READ;
                end
            end
            S_REG_SCAN:
            begin
                if (!wsts.id_ok)
                begin
                    fin    = 1'b1;
                    fin_st = ST_WORKER;
                end
                else if (wsts.cnt_done || wsts.free_here)
                begin
                    wcmd.set_mark = 1'b1;
                    wcmd.claim    = !wsts.cnt_done;
                    fin           = 1'b1;
                    fin_st        = ST_WORKER;
                end
                else
                begin
                    wcmd.advance = 1'b1;
                end
            end
            S_UNREG_READ:
            begin
                if (!wsts.id_ok || wsts.cnt_done)
                begin
                    wcmd.clr_mark = 1'b1;
                    fin           = 1'b1;
                    fin_st        = ST_WORKER;
                end
                else
                begin
                    state_next = S_UNREG_CHECK;
                end
            end
            S_UNREG_CHECK:
            begin
                if (wsts.match_here)
                begin
                    wcmd.release_slot = 1'b1;
                    wcmd.clr_mark     = 1'b1;
                    fin               = 1'b1;
                    fin_st            = ST_WORKER;
                end
                else
                begin
                    wcmd.advance = 1'b1;
                    state_next   = S_UNREG_READ;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next       = 1'b1;
                    result_next.status      = fin_status_reg;
                    result_next.dest_worker = fin_target_reg;
                    state_next              = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (fin)
        begin
            fin_status_next = fin_st;
            fin_target_next = fin_tg;
            state_next      = S_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            enabled_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            enabled_reg      <= enabled_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        fin_status_reg <= fin_status_next;
        fin_target_reg <= fin_target_next;
        result_reg     <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_accept_works: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted request left no work behind");

    a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_reg.status != ST_MAPPED)
            && (result_reg.status != ST_RR)) |-> (result_reg.dest_worker == 4'd0))
        else $error("target set on a request that was not sent");

endmodule

// ===== design/flow_to_worker_steering.sv =====
// Flow steering: each request is a packet to steer, a flow add or remove, or a
// worker register or unregister, and each request gives exactly one result
// (status plus target worker, target zero unless the packet was sent). The
// block works on one request at a time. The flow table is a memory with one
// write port and one registered read port, scanned one entry at a time (read,
// then compare) and stopping at a hit; on a miss a packet, add or remove
// looks at all FLOW_ENTRIES entries. A packet that misses then walks the
// worker slots from the round-robin pointer, one attempt at a time (read,
// then check), up to the active slot count, and finishes with no worker when
// no used slot turns up. Register looks at the slots one by one for a free
// one, unregister reads and then compares each slot for the worker, each
// stopping at a find or past the last active slot. Disabled, short and
// zero-key packets finish in the accept cycle. Every request moves its result
// into the output register from S_DONE; that register can hold a finished
// result while the next request is accepted. After reset the flow table is
// swept clear entry by entry and item_stall stays high until the sweep is done;
// configuration writes are taken at any time but belong in idle periods.
// slot_count of zero acts as 1, values above WORKER_SLOTS act as WORKER_SLOTS.
module flow_to_worker_steering #(
    parameter int FLOW_ENTRIES = fts_pkg::FLOW_ENTRIES_DEF,
    parameter int WORKER_IDS   = fts_pkg::WORKER_IDS_DEF,
    parameter int WORKER_SLOTS = fts_pkg::WORKER_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  fts_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output fts_pkg::result_t                result,
    input  logic                            cfg_write,
    input  logic [fts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fts_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fts_pkg::*;

    flow_cmd_t fcmd;
    flow_sts_t fsts;
    wrk_cmd_t  wcmd;
    wrk_sts_t  wsts;

    // flow table: key memory, scan counter, hit and free-entry tracking
    fts_flow_table #(
        .FLOW_ENTRIES(FLOW_ENTRIES)
    ) u_flow (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cmd   (fcmd),
        .sts   (fsts)
    );

    // worker marks, slot table and round-robin pointer; also checks the
    // mapped worker of a flow hit
    fts_workers #(
        .WORKER_IDS   (WORKER_IDS),
        .WORKER_SLOTS (WORKER_SLOTS)
    ) u_workers (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item       (item),
        .hit_worker (fsts.hit_worker),
        .cmd        (wcmd),
        .sts        (wsts)
    );

    // sequencer: decodes the request, runs the scans, owns the result register
    fts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fsts         (fsts),
        .wsts         (wsts),
        .fcmd         (fcmd),
        .wcmd         (wcmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
